@@ hw/rtl/printer_status_reply_parser_macros.svh @@
// assertion macros for the printer status reply parser
`ifndef PRINTER_STATUS_REPLY_PARSER_MACROS_SVH
`define PRINTER_STATUS_REPLY_PARSER_MACROS_SVH

// same-cycle implication, checked outside reset
`define PSR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/psr_pkg.sv @@
// shared types, codes and reply decode for the printer status reply parser
`timescale 1ns / 1ps
package psr_pkg;

    localparam int REPLY_DEPTH = 8;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;
    localparam logic [15:0] TICKS_MAX = 16'hFFFF;

    // opcodes
    localparam logic [1:0] OP_POLL      = 2'd0;
    localparam logic [1:0] OP_POLL_BYTE = 2'd1;
    localparam logic [1:0] OP_TICK      = 2'd2;

    // characters
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_0 = 8'h30;
    localparam logic [7:0] CH_1 = 8'h31;
    localparam logic [7:0] CH_2 = 8'h32;
    localparam logic [7:0] CH_3 = 8'h33;
    localparam logic [7:0] CH_4 = 8'h34;
    localparam logic [7:0] CH_5 = 8'h35;
    localparam logic [7:0] CH_6 = 8'h36;
    localparam logic [7:0] CH_7 = 8'h37;
    localparam logic [7:0] CH_8 = 8'h38;

    // status codes
    localparam logic [3:0] ST_BUSY     = 4'd0;
    localparam logic [3:0] ST_OK       = 4'd1;
    localparam logic [3:0] ST_OFF      = 4'd2;
    localparam logic [3:0] ST_OPEN     = 4'd3;
    localparam logic [3:0] ST_LOADED   = 4'd4;
    localparam logic [3:0] ST_PAUSE    = 4'd5;
    localparam logic [3:0] ST_HARD     = 4'd6;
    localparam logic [3:0] ST_JAM      = 4'd7;
    localparam logic [3:0] ST_NOPAPER  = 4'd8;
    localparam logic [3:0] ST_NORIBBON = 4'd9;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_DATA  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic [3:0] status;
        logic       send_query;
    } t_result;

    // two-digit code plus ready byte to dense status
    function automatic logic [3:0] decode_reply(input logic [7:0] a, input logic [7:0] b,
                                                input logic [7:0] c);
        logic [3:0] st;
        st = ST_BUSY;
        if (c == CH_0) begin
            st = ST_BUSY;
        end else if (a == CH_0) begin
            case (b)
                CH_0: st = ST_OK;
                CH_1: st = ST_OPEN;
                CH_2, CH_5: st = ST_LOADED;
                CH_4: st = ST_PAUSE;
                CH_6, CH_7: st = ST_HARD;
                default: st = ST_BUSY;
            endcase
        end else if (a == CH_1) begin
            case (b)
                CH_1: st = ST_JAM;
                CH_2, CH_8: st = ST_HARD;
                CH_3: st = ST_NOPAPER;
                CH_4: st = ST_NORIBBON;
                CH_5: st = ST_OPEN;
                default: st = ST_BUSY;
            endcase
        end else if (a == CH_2 && b == CH_1) begin
            st = ST_NORIBBON;
        end
        return st;
    endfunction

endpackage

@@ hw/rtl/psr_in_if.sv @@
// input word channel: opcode and received byte
`timescale 1ns / 1ps
interface psr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

@@ hw/rtl/psr_out_if.sv @@
// result word channel: status and query request
`timescale 1ns / 1ps
interface psr_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] status;
    logic       send_query;

    modport source (output valid, output status, output send_query, input ready);
    modport sink (input valid, input status, input send_query, output ready);
endinterface

@@ hw/rtl/psr_cfg_if.sv @@
// configuration write channel for the timeout limit
`timescale 1ns / 1ps
interface psr_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] timeout_limit;

    modport source (output valid, output timeout_limit, input ready);
    modport sink (input valid, input timeout_limit, output ready);
endinterface

@@ hw/rtl/psr_in_stage.sv @@
// input register stage
`timescale 1ns / 1ps
module psr_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  psr_pkg::t_item  i_item,
    input  logic            i_take,
    output logic            o_valid,
    output psr_pkg::t_item  o_item
);
    logic           r_valid;
    psr_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end
endmodule

@@ hw/rtl/psr_core.sv @@
// poll state machine, reply store, tick counter and decode
`timescale 1ns / 1ps
module psr_core #(
    parameter int REPLY_DEPTH = psr_pkg::REPLY_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  psr_pkg::t_item   i_item,
    input  logic             i_out_free,
    input  logic [15:0]      i_timeout_limit,
    output logic             o_take,
    output logic             o_res_valid,
    output psr_pkg::t_result o_result
);
    localparam int CW = $clog2(REPLY_DEPTH + 1);
    localparam int IW = $clog2(REPLY_DEPTH);

    psr_pkg::t_phase r_phase, n_phase;
    logic [CW-1:0]   r_fill, n_fill;
    logic [15:0]     r_ticks, n_ticks;
    logic [7:0]      r_bytes [REPLY_DEPTH];
    logic            w_wr_en;
    logic            w_poll;

    // ticks need no result slot, polls do; opcode 3 is dropped
    assign w_poll      = (i_item.opcode == psr_pkg::OP_POLL) ||
                         (i_item.opcode == psr_pkg::OP_POLL_BYTE);
    assign o_take      = i_valid && (i_out_free || !w_poll);
    assign o_res_valid = i_valid && i_out_free && w_poll;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= psr_pkg::PH_IDLE;
            r_fill  <= '0;
            r_ticks <= '0;
        end else begin
            r_phase <= n_phase;
            r_fill  <= n_fill;
            r_ticks <= n_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REPLY_DEPTH; i++) begin
                r_bytes[i] <= '0;
            end
        end else begin
            for (int i = 0; i < REPLY_DEPTH; i++) begin
                if (w_wr_en && r_fill[IW-1:0] == IW'(i)) begin
                    r_bytes[i] <= i_item.rx_byte;
                end
            end
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_fill   = r_fill;
        n_ticks  = r_ticks;
        w_wr_en  = 1'b0;
        o_result = '{status: psr_pkg::ST_BUSY, send_query: 1'b0};
        if (o_take && i_item.opcode == psr_pkg::OP_TICK) begin
            if (r_ticks != psr_pkg::TICKS_MAX) begin
                n_ticks = r_ticks + 16'd1;
            end
        end else if (o_res_valid) begin
            unique case (r_phase)
                psr_pkg::PH_IDLE: begin
                    n_fill  = '0;
                    n_ticks = '0;
                    n_phase = psr_pkg::PH_START;
                    o_result.send_query = 1'b1;
                end
                psr_pkg::PH_START, psr_pkg::PH_DATA: begin
                    if (i_item.opcode == psr_pkg::OP_POLL) begin
                        if (r_ticks > i_timeout_limit) begin
                            n_fill  = '0;
                            n_phase = psr_pkg::PH_IDLE;
                            o_result.status = psr_pkg::ST_OFF;
                        end
                    end else if (r_phase == psr_pkg::PH_START) begin
                        n_fill = '0;
                        if (i_item.rx_byte == psr_pkg::CH_LBRACE) begin
                            n_ticks = '0;
                            n_phase = psr_pkg::PH_DATA;
                        end else begin
                            n_phase = psr_pkg::PH_IDLE;
                        end
                    end else if (i_item.rx_byte != psr_pkg::CH_RBRACE) begin
                        if (r_fill >= CW'(REPLY_DEPTH)) begin
                            n_fill  = '0;
                            n_phase = psr_pkg::PH_IDLE;
                        end else begin
                            w_wr_en = 1'b1;
                            n_fill  = r_fill + CW'(1);
                        end
                    end else begin
                        o_result.status = psr_pkg::decode_reply(r_bytes[0], r_bytes[1],
                                                                r_bytes[2]);
                        n_phase = psr_pkg::PH_IDLE;
                    end
                end
                default: begin
                    n_phase = psr_pkg::PH_IDLE;
                end
            endcase
        end
    end
endmodule

@@ hw/rtl/psr_out_stage.sv @@
// result register stage
`timescale 1ns / 1ps
module psr_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  psr_pkg::t_result i_result,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output psr_pkg::t_result o_result
);
    logic             r_valid;
    psr_pkg::t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_result <= i_result;
        end
    end
endmodule

@@ hw/rtl/printer_status_reply_parser.sv @@
// top level of the printer status reply parser
`timescale 1ns / 1ps
`include "printer_status_reply_parser_macros.svh"
// polls a label printer for status and parses its reply. each input word is
// a poll (with or without a received byte) or a centisecond tick. a poll
// yields exactly one result word, a tick and opcode 3 yield none. a poll in
// idle returns send_query=1: the host flushes its receive buffer and sends
// the status query. the block then waits for '{', stores up to REPLY_DEPTH
// bytes and decodes the first three at '}'. a bare poll after more than
// timeout_limit ticks reports printer off. throughput is one word per clock:
// a word is held in the input register, the state machine handles it in a
// single pass and the result lands in the output register, which drives
// o_out.valid. a poll waits in the input register only while the result
// register is full and not being taken; ticks pass through regardless.
// timeout_limit is written over i_cfg, which is always ready; write it only
// while the block is idle
module printer_status_reply_parser #(
    parameter int REPLY_DEPTH = psr_pkg::REPLY_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    psr_in_if.sink    i_in,
    psr_out_if.source o_out,
    psr_cfg_if.sink   i_cfg
);
    // timeout register
    logic [15:0] r_timeout_limit;

    // pipeline handshake between stages
    logic             w_in_valid;
    psr_pkg::t_item   w_in_item;
    psr_pkg::t_item   w_stage_item;
    logic             w_take;
    logic             w_res_valid;
    logic             w_out_free;
    psr_pkg::t_result w_result;
    psr_pkg::t_result w_out_result;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_limit <= psr_pkg::TIMEOUT_RESET;
        end else if (i_cfg.valid) begin
            r_timeout_limit <= i_cfg.timeout_limit;
        end
    end

    assign w_in_item = '{opcode: i_in.opcode, rx_byte: i_in.rx_byte};

    // input register
    psr_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_item  (w_in_item),
        .i_take  (w_take),
        .o_valid (w_in_valid),
        .o_item  (w_stage_item)
    );

    // single-pass state update and decode
    psr_core #(
        .REPLY_DEPTH (REPLY_DEPTH)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_in_valid),
        .i_item          (w_stage_item),
        .i_out_free      (w_out_free),
        .i_timeout_limit (r_timeout_limit),
        .o_take          (w_take),
        .o_res_valid     (w_res_valid),
        .o_result        (w_result)
    );

    // result register
    psr_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_res_valid),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_result (w_out_result)
    );

    assign o_out.status     = w_out_result.status;
    assign o_out.send_query = w_out_result.send_query;

    // a result is only produced when the result register has room
    `PSR_ASSERT_NOW(a_res_has_room, i_clk, i_rst_n, w_res_valid, w_out_free && w_take, "result without room")
    // a query request never carries a verdict
    `PSR_ASSERT_NOW(a_query_busy, i_clk, i_rst_n, w_res_valid && w_result.send_query, w_result.status == psr_pkg::ST_BUSY, "query with status")
    // held input word that was not consumed blocks new input
    `PSR_ASSERT_NOW(a_in_block, i_clk, i_rst_n, w_in_valid && !w_take, !i_in.ready, "input overrun")
    // a loaded result shows up on the port next cycle
    `PSR_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, w_res_valid, o_out.valid && o_out.status <= psr_pkg::ST_NORIBBON, "result lost")
endmodule

@@ bench/printer_status_reply_parser_test.sv @@
// self-checking bench for the printer status reply parser: directed replies, timeouts, random polling
`timescale 1ns / 1ps
module printer_status_reply_parser_test;

    // opcode 3 carries no meaning, the block must drop it silently
    localparam logic [1:0] OP_IGNORED = 2'd3;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int SETTLE_LIMIT = 5000;
    localparam int WORDS_PER_PHASE = 130;
    localparam int REPORT_LINES = 50;

    // receiver stall behavior, switched at random by the receiver process
    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_SLOW,
        RX_RHYTHM
    } t_rx_mode;

    // keeps its own copy of the parser state and the timeout limit, and queues
    // the status word that each accepted poll must produce
    class status_scoreboard;
        psr_pkg::t_result expected_status_q[$];
        psr_pkg::t_phase  phase;
        logic [7:0]       reply_bytes[psr_pkg::REPLY_DEPTH];
        int unsigned      fill_count;
        logic [15:0]      elapsed_ticks;
        logic [15:0]      timeout_limit;

        function new();
            phase = psr_pkg::PH_IDLE;
            foreach (reply_bytes[i]) reply_bytes[i] = 8'h00;
            fill_count = 0;
            elapsed_ticks = 16'd0;
            timeout_limit = psr_pkg::TIMEOUT_RESET;
        endfunction

        function void set_limit(logic [15:0] value);
            timeout_limit = value;
        endfunction

        function int pending();
            return expected_status_q.size();
        endfunction

        // two-digit code in the first two stored bytes, third byte '0' is not ready
        function logic [3:0] reply_status();
            logic [3:0] st;
            st = psr_pkg::ST_BUSY;
            if (reply_bytes[2] != psr_pkg::CH_0) begin
                case ({reply_bytes[0], reply_bytes[1]})
                    {psr_pkg::CH_0, psr_pkg::CH_0}: st = psr_pkg::ST_OK;
                    {psr_pkg::CH_0, psr_pkg::CH_1}: st = psr_pkg::ST_OPEN;
                    {psr_pkg::CH_0, psr_pkg::CH_2}: st = psr_pkg::ST_LOADED;
                    {psr_pkg::CH_0, psr_pkg::CH_4}: st = psr_pkg::ST_PAUSE;
                    {psr_pkg::CH_0, psr_pkg::CH_5}: st = psr_pkg::ST_LOADED;
                    {psr_pkg::CH_0, psr_pkg::CH_6}: st = psr_pkg::ST_HARD;
                    {psr_pkg::CH_0, psr_pkg::CH_7}: st = psr_pkg::ST_HARD;
                    {psr_pkg::CH_1, psr_pkg::CH_1}: st = psr_pkg::ST_JAM;
                    {psr_pkg::CH_1, psr_pkg::CH_2}: st = psr_pkg::ST_HARD;
                    {psr_pkg::CH_1, psr_pkg::CH_3}: st = psr_pkg::ST_NOPAPER;
                    {psr_pkg::CH_1, psr_pkg::CH_4}: st = psr_pkg::ST_NORIBBON;
                    {psr_pkg::CH_1, psr_pkg::CH_5}: st = psr_pkg::ST_OPEN;
                    {psr_pkg::CH_1, psr_pkg::CH_8}: st = psr_pkg::ST_HARD;
                    {psr_pkg::CH_2, psr_pkg::CH_1}: st = psr_pkg::ST_NORIBBON;
                    default: st = psr_pkg::ST_BUSY;
                endcase
            end
            return st;
        endfunction

        function void note_word(psr_pkg::t_item w);
            psr_pkg::t_result r;
            logic             has_result;
            r.status = psr_pkg::ST_BUSY;
            r.send_query = 1'b0;
            has_result = 1'b1;
            case (w.opcode)
                psr_pkg::OP_TICK: begin
                    if (elapsed_ticks != psr_pkg::TICKS_MAX) elapsed_ticks++;
                    has_result = 1'b0;
                end
                psr_pkg::OP_POLL, psr_pkg::OP_POLL_BYTE: begin
                    if (phase == psr_pkg::PH_IDLE) begin
                        // byte is flushed, query goes out
                        fill_count = 0;
                        elapsed_ticks = 16'd0;
                        phase = psr_pkg::PH_START;
                        r.send_query = 1'b1;
                    end else if (w.opcode == psr_pkg::OP_POLL) begin
                        if (elapsed_ticks > timeout_limit) begin
                            fill_count = 0;
                            phase = psr_pkg::PH_IDLE;
                            r.status = psr_pkg::ST_OFF;
                        end
                    end else if (phase == psr_pkg::PH_START) begin
                        fill_count = 0;
                        if (w.rx_byte == psr_pkg::CH_LBRACE) begin
                            elapsed_ticks = 16'd0;
                            phase = psr_pkg::PH_DATA;
                        end else begin
                            phase = psr_pkg::PH_IDLE;
                        end
                    end else if (w.rx_byte != psr_pkg::CH_RBRACE) begin
                        if (fill_count >= psr_pkg::REPLY_DEPTH) begin
                            fill_count = 0;
                            phase = psr_pkg::PH_IDLE;
                        end else begin
                            reply_bytes[fill_count] = w.rx_byte;
                            fill_count++;
                        end
                    end else begin
                        r.status = reply_status();
                        phase = psr_pkg::PH_IDLE;
                    end
                end
                default: has_result = 1'b0;
            endcase
            if (has_result) expected_status_q.push_back(r);
        endfunction

        function bit check_word(psr_pkg::t_result got, output string why);
            psr_pkg::t_result want;
            why = "";
            if (expected_status_q.size() == 0) begin
                why = $sformatf(" status %0d query %0b with nothing expected",
                                got.status, got.send_query);
                return 1'b0;
            end
            want = expected_status_q.pop_front();
            if (got.status !== want.status)
                why = {why, $sformatf(" status got %0d want %0d", got.status, want.status)};
            if (got.send_query !== want.send_query)
                why = {why, $sformatf(" send_query got %0b want %0b", got.send_query,
                                      want.send_query)};
            return why == "";
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    psr_in_if  in_ch ();
    psr_out_if out_ch ();
    psr_cfg_if cfg_ch ();

    printer_status_reply_parser dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    status_scoreboard sb;
    int          mismatches = 0;
    int          words_sent = 0;
    int          results_checked = 0;
    int          limits_used = 1;
    int          burst_left = 0;
    logic [15:0] cur_limit = psr_pkg::TIMEOUT_RESET;
    logic [15:0] statuses_seen = 16'h0000;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_LINES) $display("[%0t] result word mismatch:%s", $time, what);
    endtask

    // all handshakes are sampled here, at the edge where they complete
    always @(posedge clk) begin
        psr_pkg::t_item   w;
        psr_pkg::t_result got;
        string            why;
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) sb.set_limit(cfg_ch.timeout_limit);
            if (in_ch.valid && in_ch.ready) begin
                w.opcode = in_ch.opcode;
                w.rx_byte = in_ch.rx_byte;
                sb.note_word(w);
            end
            if (out_ch.valid && out_ch.ready) begin
                got.status = out_ch.status;
                got.send_query = out_ch.send_query;
                results_checked++;
                statuses_seen[got.status] = 1'b1;
                if (!sb.check_word(got, why)) report_mismatch(why);
            end
        end
    end

    // receiver: ready follows a mode that is picked at random and changes from run to run of random length
    initial begin
        t_rx_mode rx_mode;
        int       mode_left;
        rx_mode = RX_FREE;
        mode_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (mode_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (rx_mode)
                RX_FREE: out_ch.ready <= 1'b1;
                RX_COIN: out_ch.ready <= 1'($urandom_range(0, 1));
                RX_SLOW: out_ch.ready <= ($urandom_range(0, 3) == 0);
                default: out_ch.ready <= (mode_left % 5) < 2;
            endcase
        end
    end

    // sender: bursts of back-to-back words, random gaps between bursts
    task automatic put_word(input logic [1:0] op, input logic [7:0] data);
        int gap;
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 16);
        end
        in_ch.valid <= 1'b1;
        in_ch.opcode <= op;
        in_ch.rx_byte <= data;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        burst_left--;
        if (op != OP_IGNORED) words_sent++;
    endtask

    task automatic put_ticks(input int count);
        repeat (count) put_word(psr_pkg::OP_TICK, 8'($urandom));
    endtask

    // drop valid and wait for every queued status word plus pipeline slack
    task automatic settle();
        int waited;
        waited = 0;
        in_ch.valid <= 1'b0;
        burst_left = 0;
        repeat (2) @(posedge clk);
        while (sb.pending() != 0 && waited < SETTLE_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.timeout_limit <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        cur_limit = value;
        limits_used++;
    endtask

    function automatic logic [7:0] digit();
        return psr_pkg::CH_0 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] not_close();
        logic [7:0] b;
        do b = 8'($urandom); while (b == psr_pkg::CH_RBRACE);
        return b;
    endfunction

    // codes the printer is known to send
    function automatic logic [15:0] known_code();
        case ($urandom_range(0, 13))
            0: return {psr_pkg::CH_0, psr_pkg::CH_0};
            1: return {psr_pkg::CH_0, psr_pkg::CH_1};
            2: return {psr_pkg::CH_0, psr_pkg::CH_2};
            3: return {psr_pkg::CH_0, psr_pkg::CH_4};
            4: return {psr_pkg::CH_0, psr_pkg::CH_5};
            5: return {psr_pkg::CH_0, psr_pkg::CH_6};
            6: return {psr_pkg::CH_0, psr_pkg::CH_7};
            7: return {psr_pkg::CH_1, psr_pkg::CH_1};
            8: return {psr_pkg::CH_1, psr_pkg::CH_2};
            9: return {psr_pkg::CH_1, psr_pkg::CH_3};
            10: return {psr_pkg::CH_1, psr_pkg::CH_4};
            11: return {psr_pkg::CH_1, psr_pkg::CH_5};
            12: return {psr_pkg::CH_1, psr_pkg::CH_8};
            default: return {psr_pkg::CH_2, psr_pkg::CH_1};
        endcase
    endfunction

    // a few ticks, sometimes a bare poll that may hit the timeout, rarely a dead opcode
    task automatic idle_ticks();
        if ($urandom_range(0, 2) == 0) begin
            put_ticks($urandom_range(0, 3));
            if ($urandom_range(0, 1) == 0) put_word(psr_pkg::OP_POLL, 8'($urandom));
            if ($urandom_range(0, 7) == 0) put_word(OP_IGNORED, 8'($urandom));
        end
    endtask

    // one poll exchange; mostly well-formed replies, some broken ones, some noise
    task automatic random_exchange();
        int          kind;
        int          n_bytes;
        logic [15:0] code;
        logic [7:0]  data;
        kind = $urandom_range(0, 99);
        if (kind >= 94) begin
            repeat ($urandom_range(1, 4)) put_word(2'($urandom_range(0, 3)), 8'($urandom));
            return;
        end
        put_word($urandom_range(0, 1) ? psr_pkg::OP_POLL_BYTE : psr_pkg::OP_POLL,
                 8'($urandom));
        idle_ticks();
        if (kind < 8) begin
            // anything but '{' where the start byte belongs
            do data = 8'($urandom); while (data == psr_pkg::CH_LBRACE);
            put_word(psr_pkg::OP_POLL_BYTE, data);
            return;
        end
        if (kind < 14 && cur_limit < 16'd400) begin
            // straddle the limit so both sides of the compare show up
            put_ticks(int'(cur_limit) + $urandom_range(0, 2));
            put_word(psr_pkg::OP_POLL, 8'($urandom));
            return;
        end
        put_word(psr_pkg::OP_POLL_BYTE, psr_pkg::CH_LBRACE);
        code = ($urandom_range(0, 9) < 7) ? known_code() : {digit(), digit()};
        case ($urandom_range(0, 9))
            0: n_bytes = $urandom_range(0, 2);      // short reply, stale bytes decoded
            1: n_bytes = psr_pkg::REPLY_DEPTH;      // exactly full
            2: n_bytes = psr_pkg::REPLY_DEPTH + 1;  // overflow, no closing brace
            default: n_bytes = $urandom_range(3, 5);
        endcase
        for (int i = 0; i < n_bytes; i++) begin
            if (i == 0) data = code[15:8];
            else if (i == 1) data = code[7:0];
            else if (i == 2) data = ($urandom_range(0, 5) == 0) ? psr_pkg::CH_0
                                  : ($urandom_range(0, 1) ? psr_pkg::CH_1 : not_close());
            else data = not_close();
            put_word(psr_pkg::OP_POLL_BYTE, data);
            if ($urandom_range(0, 5) == 0) idle_ticks();
        end
        if (n_bytes <= psr_pkg::REPLY_DEPTH) put_word(psr_pkg::OP_POLL_BYTE, psr_pkg::CH_RBRACE);
    endtask

    task automatic random_phase();
        int target;
        target = words_sent + WORDS_PER_PHASE;
        while (words_sent < target) random_exchange();
    endtask

    // cycle budget covers the worst stall pattern with room to spare
    initial begin
        int n;
        n = 0;
        while (n < CYCLE_LIMIT) begin
            @(posedge clk);
            n++;
        end
        $display("timeout after %0d cycles, %0d results still expected", n, sb.pending());
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        sb = new();
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.opcode <= psr_pkg::OP_POLL;
        in_ch.rx_byte <= 8'h00;
        cfg_ch.valid <= 1'b0;
        cfg_ch.timeout_limit <= psr_pkg::TIMEOUT_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limit of 100: dead opcode, flushed byte, bad start, decode
        put_word(OP_IGNORED, 8'hFF);
        put_word(psr_pkg::OP_POLL_BYTE, 8'hFF);
        put_word(psr_pkg::OP_POLL_BYTE, 8'h00);
        put_word(psr_pkg::OP_POLL, 8'h00);
        put_word(psr_pkg::OP_POLL, 8'h00);
        put_word(psr_pkg::OP_POLL_BYTE, psr_pkg::CH_LBRACE);
        put_word(psr_pkg::OP_POLL_BYTE, psr_pkg::CH_1);
        put_word(psr_pkg::OP_POLL_BYTE, psr_pkg::CH_3);
        put_word(psr_pkg::OP_POLL_BYTE, psr_pkg::CH_5);
        put_word(psr_pkg::OP_POLL_BYTE, psr_pkg::CH_RBRACE);
        // printer not ready
        put_word(psr_pkg::OP_POLL, 8'h00);
        put_word(psr_pkg::OP_POLL_BYTE, psr_pkg::CH_LBRACE);
        repeat (3) put_word(psr_pkg::OP_POLL_BYTE, psr_pkg::CH_0);
        put_word(psr_pkg::OP_POLL_BYTE, psr_pkg::CH_RBRACE);
        // overflow with extreme data bytes
        put_word(psr_pkg::OP_POLL, 8'h00);
        put_word(psr_pkg::OP_POLL_BYTE, psr_pkg::CH_LBRACE);
        for (int i = 0; i <= psr_pkg::REPLY_DEPTH; i++)
            put_word(psr_pkg::OP_POLL_BYTE, i[0] ? 8'hFF : 8'h00);
        // exactly at the limit is still waiting, one more tick is off
        put_word(psr_pkg::OP_POLL, 8'h00);
        put_ticks(100);
        put_word(psr_pkg::OP_POLL, 8'h00);
        put_ticks(1);
        put_word(psr_pkg::OP_POLL, 8'h00);
        // one-byte reply decodes leftovers from the overflow
        put_word(psr_pkg::OP_POLL, 8'h00);
        put_word(psr_pkg::OP_POLL_BYTE, psr_pkg::CH_LBRACE);
        put_word(psr_pkg::OP_POLL_BYTE, psr_pkg::CH_2);
        put_word(psr_pkg::OP_POLL_BYTE, psr_pkg::CH_RBRACE);
        random_phase();
        settle();

        // smallest limit: one tick waits, two is off, '{' restarts the count
        write_limit(16'd1);
        put_word(psr_pkg::OP_POLL, 8'h00);
        put_ticks(1);
        put_word(psr_pkg::OP_POLL, 8'h00);
        put_ticks(1);
        put_word(psr_pkg::OP_POLL, 8'h00);
        put_word(psr_pkg::OP_POLL, 8'h00);
        put_ticks(2);
        put_word(psr_pkg::OP_POLL_BYTE, psr_pkg::CH_LBRACE);
        put_ticks(1);
        put_word(psr_pkg::OP_POLL, 8'h00);
        put_ticks(1);
        put_word(psr_pkg::OP_POLL, 8'h00);
        random_phase();
        settle();

        // largest limit: a long wait never times out
        write_limit(16'hFFFF);
        put_word(psr_pkg::OP_POLL, 8'h00);
        put_ticks(150);
        put_word(psr_pkg::OP_POLL, 8'h00);
        put_word(psr_pkg::OP_POLL_BYTE, psr_pkg::CH_LBRACE);
        put_word(psr_pkg::OP_POLL_BYTE, psr_pkg::CH_1);
        put_word(psr_pkg::OP_POLL_BYTE, psr_pkg::CH_1);
        put_word(psr_pkg::OP_POLL_BYTE, psr_pkg::CH_1);
        put_word(psr_pkg::OP_POLL_BYTE, psr_pkg::CH_RBRACE);
        random_phase();
        settle();

        // some limit in between
        write_limit(16'($urandom_range(2, 300)));
        random_phase();
        settle();

        if (sb.pending() != 0)
            report_mismatch($sformatf(" %0d expected results never arrived", sb.pending()));
        $display("covered %0d words under %0d timeout limits, %0d status words checked",
                 words_sent, limits_used, results_checked);
        $display("status codes returned (bit per code): %b", statuses_seen[9:0]);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
